@@ src/atan2_cubic_table_interp_defines.svh @@
// Assertion macros shared by the atan2 table interpolator RTL.
`ifndef ATAN2_CUBIC_TABLE_INTERP_DEFINES_SVH
`define ATAN2_CUBIC_TABLE_INTERP_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define A2CT_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("a2ct assertion failed");

// Next-cycle implication, disabled while reset is held.
`define A2CT_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("a2ct assertion failed");

`endif

@@ src/a2ct_pkg.sv @@
// Types, constants and ROM generator for the atan2 table interpolator.
package a2ct_pkg;

    localparam int DIV_CELLS    = 17;
    localparam int SERIES_TERMS = 24;

    localparam longint unsigned Q30_QUARTER_PI_U = 64'd843314857;
    localparam logic signed [35:0] Q30_HALF_PI = 36'sd1686629713;
    localparam logic signed [35:0] Q30_PI      = 36'sd3373259426;
    localparam logic signed [15:0] ANGLE_MAX   = 16'sd25736;
    localparam logic [15:0]        RECIP3      = 16'd43691;

    // Octant flags of one request
    typedef struct packed {
        logic swapped;
        logic neg_x;
        logic neg_y;
    } side_t;

    // State handed from one divider cell to the next
    typedef struct packed {
        logic [16:0] rem;
        logic [15:0] den;
        logic [16:0] quo;
        side_t       side;
    } div_lane_t;

    // unsigned a / b by shift and subtract, used only while building the ROM
    function automatic longint unsigned udiv(longint unsigned a, longint unsigned b);
        longint unsigned q;
        longint unsigned r;
        q = 0;
        r = 0;
        for (int i = 63; i >= 0; i--) begin
            r = {r[62:0], a[i]};
            if (r >= b) begin
                r    = r - b;
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // atan(t), t and result in Q.30, for small t
    function automatic longint unsigned atan_series(longint unsigned t);
        longint unsigned t2;
        longint unsigned p;
        longint          acc;
        longint          term;
        t2  = (t * t) >> 30;
        p   = t;
        acc = 0;
        for (int n = 0; n < SERIES_TERMS; n++) begin
            term = longint'(udiv(p, longint'(2 * n + 1)));
            if (n[0])
                acc = acc - term;
            else
                acc = acc + term;
            p = (p * t2) >> 30;
        end
        return longint'(acc);
    endfunction

    // atan(n/d) in Q.30
    function automatic longint unsigned atan_ratio(longint unsigned n, longint unsigned d);
        if (n * 5 <= d * 2)
            return atan_series(udiv(n << 30, d));
        if (n >= d)
            return Q30_QUARTER_PI_U + atan_series(udiv((n - d) << 30, n + d));
        return Q30_QUARTER_PI_U - atan_series(udiv((d - n) << 30, n + d));
    endfunction

    // ROM entry j: atan((j-1)/tp) in Q1.15, rounded half away from zero
    function automatic logic signed [15:0] rom_entry(int j, int tp);
        int              k;
        longint unsigned mag;
        longint unsigned q;
        logic [15:0]     q16;
        k   = j - 1;
        mag = (k < 0) ? longint'(-k) : longint'(k);
        q   = (atan_ratio(mag, longint'(tp)) + 64'd16384) >> 15;
        q16 = q[15:0];
        return (k < 0) ? -$signed(q16) : $signed(q16);
    endfunction

endpackage

@@ src/a2ct_div_cell.sv @@
// One restoring-division cell: settles one quotient bit per request per cycle while en is high.
module a2ct_div_cell (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  logic                  valid_i,
    input  a2ct_pkg::div_lane_t   lane_i,
    output logic                  valid_o,
    output a2ct_pkg::div_lane_t   lane_o
);
    import a2ct_pkg::*;

    logic        ge;
    logic [16:0] diff;
    logic [16:0] rem_sel;
    div_lane_t   lane_next;
    div_lane_t   lane_reg;
    logic        valid_reg;

    // trial subtract, keep or restore, shift left
    always_comb begin
        ge             = lane_i.rem >= {1'b0, lane_i.den};
        diff           = lane_i.rem - {1'b0, lane_i.den};
        rem_sel        = ge ? diff : lane_i.rem;
        lane_next.rem  = {rem_sel[15:0], 1'b0};
        lane_next.den  = lane_i.den;
        lane_next.quo  = {lane_i.quo[15:0], ge};
        lane_next.side = lane_i.side;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= valid_i;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            lane_reg <= lane_next;
        end
    end

    assign valid_o = valid_reg;
    assign lane_o  = lane_reg;

endmodule

@@ src/a2ct_interp.sv @@
// Table index, cubic Lagrange weights, interpolation, octant fix and rounding.
module a2ct_interp #(
    parameter int TABLE_POINTS = 64
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              valid_i,
    input  logic [16:0]       ratio_i,
    input  a2ct_pkg::side_t   side_i,
    output logic              valid_o,
    output logic [15:0]       angle_o
);
    import a2ct_pkg::*;

    localparam int ROM_LEN = TABLE_POINTS + 4;
    localparam int ADDR_W  = $clog2(ROM_LEN);
    localparam int PROD_W  = 17 + $clog2(TABLE_POINTS + 1);
    localparam int STAGES  = 9;

    // arctangent ROM built at elaboration
    logic signed [15:0] rom_w [ROM_LEN];
    for (genvar j = 0; j < ROM_LEN; j++) begin : g_rom
        localparam logic signed [15:0] RomVal = rom_entry(j, TABLE_POINTS);
        assign rom_w[j] = RomVal;
    end

    logic  [STAGES-1:0] valid_reg;
    side_t              side_reg [STAGES];

    // valid and octant flags ride along every stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[STAGES-2:0], valid_i};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg[0] <= side_i;
            for (int s = 1; s < STAGES; s++) begin
                side_reg[s] <= side_reg[s-1];
            end
        end
    end

    // stage 1: index and fraction
    logic [PROD_W-1:0] prod;
    logic [ADDR_W-1:0] idx_next;
    logic [ADDR_W-1:0] idx1_reg;
    logic [15:0]       f1_reg;

    always_comb begin
        prod = PROD_W'(ratio_i) * PROD_W'(TABLE_POINTS);
        if (prod[PROD_W-1:16] > (PROD_W - 16)'(TABLE_POINTS))
            idx_next = ADDR_W'(TABLE_POINTS);
        else
            idx_next = ADDR_W'(prod[PROD_W-1:16]);
    end

    // stage 2: pair products of the weight factors, ROM reads
    logic [16:0] fa;
    logic [16:0] fb;
    logic [17:0] fc;
    logic [16:0] fd;
    logic [32:0] ab2_reg;
    logic [34:0] dc2_reg;
    logic [32:0] da2_reg;
    logic [16:0] b2_reg;
    logic [17:0] c2_reg;
    logic signed [15:0] r2_reg [4];

    always_comb begin
        fa = {1'b0, f1_reg};
        fb = 17'h10000 - {1'b0, f1_reg};
        fc = 18'h20000 - {2'b00, f1_reg};
        fd = 17'h10000 + {1'b0, f1_reg};
    end

    // stage 3: triple products
    logic [51:0] abc3_reg;
    logic [51:0] dbc3_reg;
    logic [51:0] dac3_reg;
    logic [51:0] dab3_reg;
    logic signed [15:0] r3_reg [4];

    // stage 4: rounding shifts
    logic [51:0] sa4;
    logic [51:0] sb4;
    logic [51:0] sc4;
    logic [51:0] sd4;
    logic [14:0] ua4_reg;
    logic [14:0] ud4_reg;
    logic [15:0] wb4_reg;
    logic [15:0] wc4_reg;
    logic signed [15:0] r4_reg [4];

    always_comb begin
        sa4 = abc3_reg + (52'd3 << 33);
        sb4 = dbc3_reg + (52'd1 << 33);
        sc4 = dac3_reg + (52'd1 << 33);
        sd4 = dab3_reg + (52'd3 << 33);
    end

    // stage 5: divide by three via reciprocal, final weights
    logic [30:0] qa5;
    logic [30:0] qd5;
    logic signed [16:0] w5_reg [4];
    logic signed [15:0] r5_reg [4];

    always_comb begin
        qa5 = 31'(ua4_reg) * 31'(RECIP3);
        qd5 = 31'(ud4_reg) * 31'(RECIP3);
    end

    // stage 6: tap products
    logic signed [32:0] p6_reg [4];

    // stage 7: sum
    logic signed [34:0] s7_reg;

    // stage 8: quadrant folds
    logic signed [35:0] a1;
    logic signed [35:0] a2_next;
    logic signed [35:0] a8_reg;

    always_comb begin
        a1      = side_reg[6].swapped ? Q30_HALF_PI - 36'(s7_reg) : 36'(s7_reg);
        a2_next = side_reg[6].neg_x ? Q30_PI - a1 : a1;
    end

    // stage 9: round half away, saturate, apply y sign
    logic [35:0] mag9;
    logic [35:0] rsum9;
    logic [15:0] rsat9;
    logic        neg9;
    logic [15:0] angle_next;
    logic [15:0] angle_reg;

    always_comb begin
        mag9  = a8_reg[35] ? 36'(-a8_reg) : 36'(a8_reg);
        rsum9 = mag9 + 36'h10000;
        if (rsum9[35:17] > 19'(ANGLE_MAX))
            rsat9 = ANGLE_MAX;
        else
            rsat9 = rsum9[32:17];
        neg9       = a8_reg[35] ^ side_reg[7].neg_y;
        angle_next = neg9 ? -rsat9 : rsat9;
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        if (en) begin
            idx1_reg <= idx_next;
            f1_reg   <= prod[15:0];

            ab2_reg <= 33'(fa[15:0]) * 33'(fb);
            dc2_reg <= 35'(fd) * 35'(fc);
            da2_reg <= 33'(fd) * 33'(fa[15:0]);
            b2_reg  <= fb;
            c2_reg  <= fc;
            for (int k = 0; k < 4; k++) begin
                r2_reg[k] <= rom_w[idx1_reg + ADDR_W'(k)];
            end

            abc3_reg <= 52'(ab2_reg) * 52'(c2_reg);
            dbc3_reg <= 52'(dc2_reg) * 52'(b2_reg);
            dac3_reg <= 52'(da2_reg) * 52'(c2_reg);
            dab3_reg <= 52'(da2_reg) * 52'(b2_reg);
            r3_reg   <= r2_reg;

            ua4_reg <= sa4[48:34];
            ud4_reg <= sd4[48:34];
            wb4_reg <= sb4[49:34];
            wc4_reg <= sc4[49:34];
            r4_reg  <= r3_reg;

            w5_reg[0] <= -$signed({3'b000, qa5[30:17]});
            w5_reg[1] <= $signed({1'b0, wb4_reg});
            w5_reg[2] <= $signed({1'b0, wc4_reg});
            w5_reg[3] <= -$signed({3'b000, qd5[30:17]});
            r5_reg    <= r4_reg;

            for (int k = 0; k < 4; k++) begin
                p6_reg[k] <= 33'(r5_reg[k]) * 33'(w5_reg[k]);
            end

            s7_reg <= 35'(p6_reg[0]) + 35'(p6_reg[1]) + 35'(p6_reg[2]) + 35'(p6_reg[3]);

            a8_reg <= a2_next;

            angle_reg <= angle_next;
        end
    end

    assign valid_o = valid_reg[STAGES-1];
    assign angle_o = angle_reg;

endmodule

@@ src/atan2_cubic_table_interp.sv @@
// Top level: fully pipelined atan2 by arctangent table with cubic interpolation.
// Takes one (y, x) pair per cycle on the s_ stream and returns atan2(y, x) in
// Q2.13 radians, saturated to +/-pi, on the m_ stream. The path holds 28
// registers: one fold stage, a chain of 17 restoring-division cells (one ratio
// bit each), nine stages of index, weight, interpolation and octant logic, and
// the output register; the fold register loads at the accepting edge. Throughput
// is one request per cycle; a one-entry skid buffer behind the output register
// lets the pipeline keep accepting while a result waits, and s_tready drops only
// when both are full, freezing the whole pipeline until the skid entry drains.
`include "atan2_cubic_table_interp_defines.svh"

module atan2_cubic_table_interp #(
    parameter int TABLE_POINTS = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [15:0] y_in, [31:16] x_in
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // [15:0] angle
);
    import a2ct_pkg::*;

    logic en;
    logic skid_valid_reg;
    logic m_tvalid_reg;
    logic [15:0] skid_data_reg;
    logic [15:0] m_data_reg;

    assign en = !skid_valid_reg;

    // fold to magnitudes, pick numerator and denominator
    logic [15:0] y_s;
    logic [15:0] x_s;
    logic [15:0] ax;
    logic [15:0] ay;
    div_lane_t   fold_next;
    div_lane_t   fold_lane_reg;
    logic        fold_valid_reg;

    always_comb begin
        y_s = s_tdata[15:0];
        x_s = s_tdata[31:16];
        ax  = x_s[15] ? -x_s : x_s;
        ay  = y_s[15] ? -y_s : y_s;
        fold_next.side.swapped = ax < ay;
        fold_next.side.neg_x   = x_s[15];
        fold_next.side.neg_y   = y_s[15];
        fold_next.rem = fold_next.side.swapped ? {1'b0, ax} : {1'b0, ay};
        fold_next.den = fold_next.side.swapped ? ay : ax;
        fold_next.quo = '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fold_valid_reg <= 1'b0;
        end else if (en) begin
            fold_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            fold_lane_reg <= fold_next;
        end
    end

    // divider chain
    logic      dv [DIV_CELLS+1];
    div_lane_t dl [DIV_CELLS+1];

    assign dv[0] = fold_valid_reg;
    assign dl[0] = fold_lane_reg;

    for (genvar c = 0; c < DIV_CELLS; c++) begin : g_div
        a2ct_div_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (en),
            .valid_i (dv[c]),
            .lane_i  (dl[c]),
            .valid_o (dv[c+1]),
            .lane_o  (dl[c+1])
        );
    end

    // both inputs zero gives ratio zero
    logic [16:0] ratio;
    assign ratio = (dl[DIV_CELLS].den == 16'd0) ? 17'd0 : dl[DIV_CELLS].quo;

    logic        pv;
    logic [15:0] pd;

    a2ct_interp #(
        .TABLE_POINTS (TABLE_POINTS)
    ) u_interp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .valid_i (dv[DIV_CELLS]),
        .ratio_i (ratio),
        .side_i  (dl[DIV_CELLS].side),
        .valid_o (pv),
        .angle_o (pd)
    );

    // output register with skid entry
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg   <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (m_tready) begin
                skid_valid_reg <= 1'b0;
            end
        end else if (pv) begin
            if (!m_tvalid_reg || m_tready) begin
                m_tvalid_reg <= 1'b1;
            end else begin
                skid_valid_reg <= 1'b1;
            end
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (m_tready) begin
                m_data_reg <= skid_data_reg;
            end
        end else if (pv) begin
            if (!m_tvalid_reg || m_tready) begin
                m_data_reg <= pd;
            end else begin
                skid_data_reg <= pd;
            end
        end
    end

    assign s_tready = en;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_data_reg;

    `A2CT_ASSERT_IMP(a_skid_implies_out, aclk, aresetn, skid_valid_reg, m_tvalid_reg)
    `A2CT_ASSERT_NXT(a_skid_holds, aclk, aresetn, skid_valid_reg && !m_tready, skid_valid_reg)
    `A2CT_ASSERT_IMP(a_angle_range, aclk, aresetn, m_tvalid_reg, ($signed(m_data_reg) <= ANGLE_MAX) && ($signed(m_data_reg) >= -ANGLE_MAX))

endmodule
